@@ design/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the design; define NO_ASSERTIONS to
// compile them out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

@@ design/ssd_pkg.sv @@
// ---------------------------------------------------------------------------
// ssd_pkg
// Types and constants of the step/direction sequencer.
// ---------------------------------------------------------------------------
package ssd_pkg;

    typedef struct packed {
        logic [3:0]  func;
        logic        direction;
        logic [15:0] step_count;
    } ssd_in_t;

    typedef struct packed {
        logic        step_out;
        logic        dir_out;
        logic        enable_n_out;
        logic        reset_n_out;
        logic        sleep_n_out;
        logic        busy_res;
        logic        ready_res;
        logic [15:0] pulses_done;
    } ssd_out_t;

    typedef struct packed {
        logic [7:0] step_half_period;
        logic [9:0] dir_settle_ticks;
        logic [9:0] enable_settle_ticks;
        logic [9:0] reset_settle_ticks;
        logic [9:0] wake_settle_ticks;
    } ssd_cfg_t;

    typedef struct packed {
        logic    accept;
        ssd_in_t item;
    } ssd_cmd_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_SETPINS = 2'd1,
        PH_GEN     = 2'd2,
        PH_RECONF  = 2'd3
    } ssd_phase_t;

    localparam logic [3:0] FUNC_TICK       = 4'd0;
    localparam logic [3:0] FUNC_REQUEST    = 4'd1;
    localparam logic [3:0] FUNC_STOP       = 4'd2;
    localparam logic [3:0] FUNC_ENABLE     = 4'd3;
    localparam logic [3:0] FUNC_DISABLE    = 4'd4;
    localparam logic [3:0] FUNC_RST_ASSERT = 4'd5;
    localparam logic [3:0] FUNC_RST_REL    = 4'd6;
    localparam logic [3:0] FUNC_SLEEP      = 4'd7;
    localparam logic [3:0] FUNC_WAKE       = 4'd8;

    localparam logic [2:0] CFG_STEP_HALF   = 3'd0;
    localparam logic [2:0] CFG_DIR_SETTLE  = 3'd1;
    localparam logic [2:0] CFG_EN_SETTLE   = 3'd2;
    localparam logic [2:0] CFG_RST_SETTLE  = 3'd3;
    localparam logic [2:0] CFG_WAKE_SETTLE = 3'd4;

    localparam int PIN_DIR = 0;
    localparam int PIN_EN  = 1;
    localparam int PIN_RST = 2;
    localparam int PIN_SLP = 3;

    localparam logic [12:0] SETTLE_MAX = 13'd8191;

endpackage

@@ design/ssd_core.sv @@
// ---------------------------------------------------------------------------
// ssd_core
// Sequencer state and pulse generator; advances once per transfer and
// presents the result of that transfer.
// ---------------------------------------------------------------------------
module ssd_core import ssd_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  ssd_cmd_t cmd,
    input  ssd_cfg_t cfg,
    output ssd_out_t res
);

    localparam int SUM_W = ((COUNT_WIDTH > 16) ? COUNT_WIDTH : 16) + 1;
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [SUM_W-1:0] COUNT_MAX_X = SUM_W'(COUNT_MAX);

    ssd_phase_t             phase_reg, phase_next;
    logic [3:0]             pins_now_reg, pins_now_next;
    logic [3:0]             pins_goal_reg, pins_goal_next;
    logic [15:0]            pending_reg, pending_next;
    logic [12:0]            settle_reg, settle_next;
    logic [COUNT_WIDTH-1:0] limit_reg, limit_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic [7:0]             timer_reg, timer_next;
    logic                   level_reg, level_next;
    logic                   pulsing_reg, pulsing_next;

    logic [7:0]       half_len;
    logic [3:0]       diff;
    logic [11:0]      settle_add;
    logic [13:0]      settle_sum;
    logic [12:0]      settle_sat;
    logic [SUM_W-1:0] extend_sum;
    logic [SUM_W-1:0] pending_x;
    logic [COUNT_WIDTH-1:0] pending_sat;
    logic [COUNT_WIDTH-1:0] extend_sat;

    assign half_len = (cfg.step_half_period == 8'd0) ? 8'd1 : cfg.step_half_period;

    assign diff = pins_now_reg ^ pins_goal_reg;
    assign settle_add = (diff[PIN_DIR] ? {2'b00, cfg.dir_settle_ticks}    : 12'd0)
                      + (diff[PIN_EN]  ? {2'b00, cfg.enable_settle_ticks} : 12'd0)
                      + (diff[PIN_RST] ? {2'b00, cfg.reset_settle_ticks}  : 12'd0)
                      + (diff[PIN_SLP] ? {2'b00, cfg.wake_settle_ticks}   : 12'd0);
    assign settle_sum = {1'b0, settle_reg} + {2'b00, settle_add};
    assign settle_sat = (settle_sum > {1'b0, SETTLE_MAX}) ? SETTLE_MAX : settle_sum[12:0];

    assign pending_x   = SUM_W'(pending_reg);
    assign pending_sat = (pending_x > COUNT_MAX_X) ? COUNT_MAX : pending_x[COUNT_WIDTH-1:0];

    assign extend_sum = SUM_W'(count_reg) + SUM_W'(cmd.item.step_count);
    assign extend_sat = (extend_sum > COUNT_MAX_X) ? COUNT_MAX : extend_sum[COUNT_WIDTH-1:0];

    always_comb begin
        phase_next     = phase_reg;
        pins_now_next  = pins_now_reg;
        pins_goal_next = pins_goal_reg;
        pending_next   = pending_reg;
        settle_next    = settle_reg;
        limit_next     = limit_reg;
        count_next     = count_reg;
        timer_next     = timer_reg;
        level_next     = level_reg;
        pulsing_next   = pulsing_reg;

        if (cmd.accept) begin
            unique case (cmd.item.func)
                FUNC_TICK: begin
                    // advance the pulse generator first
                    if (pulsing_reg) begin
                        if (timer_reg > 8'd1) begin
                            timer_next = timer_reg - 8'd1;
                        end else if (level_reg) begin
                            level_next = 1'b0;
                            count_next = (count_reg == COUNT_MAX) ? COUNT_MAX
                                                                  : count_reg + 1'b1;
                            timer_next = half_len;
                        end else if (count_reg >= limit_reg) begin
                            pulsing_next = 1'b0;
                            level_next   = 1'b0;
                            timer_next   = 8'd0;
                        end else begin
                            level_next = 1'b1;
                            timer_next = half_len;
                        end
                    end
                    unique case (phase_reg)
                        PH_SETPINS: begin
                            pins_now_next = pins_goal_reg;
                            if (settle_sat != 13'd0) begin
                                settle_next = settle_sat - 13'd1;
                            end else if (pending_reg != 16'd0) begin
                                settle_next  = settle_sat;
                                phase_next   = PH_GEN;
                                limit_next   = pending_sat;
                                count_next   = '0;
                                pulsing_next = 1'b1;
                                level_next   = 1'b1;
                                timer_next   = half_len;
                                pending_next = 16'd0;
                            end else begin
                                settle_next = settle_sat;
                                phase_next  = PH_IDLE;
                            end
                        end
                        PH_GEN: begin
                            if (!pulsing_next) begin
                                phase_next = PH_IDLE;
                            end
                        end
                        PH_RECONF: begin
                            if (!pulsing_next) begin
                                phase_next = PH_SETPINS;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                FUNC_REQUEST: begin
                    pins_goal_next[PIN_DIR] = cmd.item.direction;
                    pending_next = cmd.item.step_count;
                    if (phase_reg == PH_IDLE) begin
                        phase_next = PH_SETPINS;
                    end else if (phase_reg == PH_GEN) begin
                        if (pins_now_reg == pins_goal_next) begin
                            limit_next   = extend_sat;
                            pending_next = 16'd0;
                        end else begin
                            phase_next   = PH_RECONF;
                            pulsing_next = 1'b0;
                            level_next   = 1'b0;
                            timer_next   = 8'd0;
                        end
                    end
                end
                FUNC_STOP, FUNC_ENABLE, FUNC_DISABLE, FUNC_RST_ASSERT,
                FUNC_RST_REL, FUNC_SLEEP, FUNC_WAKE: begin
                    unique case (cmd.item.func)
                        FUNC_STOP:       pending_next = 16'd0;
                        FUNC_ENABLE:     pins_goal_next[PIN_EN]  = 1'b0;
                        FUNC_DISABLE:    pins_goal_next[PIN_EN]  = 1'b1;
                        FUNC_RST_ASSERT: pins_goal_next[PIN_RST] = 1'b0;
                        FUNC_RST_REL:    pins_goal_next[PIN_RST] = 1'b1;
                        FUNC_SLEEP:      pins_goal_next[PIN_SLP] = 1'b0;
                        default:         pins_goal_next[PIN_SLP] = 1'b1;
                    endcase
                    phase_next   = PH_RECONF;
                    pulsing_next = 1'b0;
                    level_next   = 1'b0;
                    timer_next   = 8'd0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            pins_now_reg  <= 4'd0;
            pins_goal_reg <= 4'd0;
            pending_reg   <= 16'd0;
            settle_reg    <= 13'd0;
            limit_reg     <= '0;
            count_reg     <= '0;
            timer_reg     <= 8'd0;
            level_reg     <= 1'b0;
            pulsing_reg   <= 1'b0;
        end else begin
            phase_reg     <= phase_next;
            pins_now_reg  <= pins_now_next;
            pins_goal_reg <= pins_goal_next;
            pending_reg   <= pending_next;
            settle_reg    <= settle_next;
            limit_reg     <= limit_next;
            count_reg     <= count_next;
            timer_reg     <= timer_next;
            level_reg     <= level_next;
            pulsing_reg   <= pulsing_next;
        end
    end

    always_comb begin
        res.step_out     = level_next;
        res.dir_out      = pins_now_next[PIN_DIR];
        res.enable_n_out = pins_now_next[PIN_EN];
        res.reset_n_out  = pins_now_next[PIN_RST];
        res.sleep_n_out  = pins_now_next[PIN_SLP];
        res.busy_res     = (phase_next != PH_IDLE);
        res.ready_res    = !pins_now_next[PIN_EN] && pins_now_next[PIN_RST]
                           && pins_now_next[PIN_SLP];
        res.pulses_done  = 16'(count_next);
    end

endmodule

@@ design/stepper_step_dir_sequencer.sv @@
// ---------------------------------------------------------------------------
// stepper_step_dir_sequencer
// Step/direction stepper driver sequencer with settle waits and pulse runs.
// ---------------------------------------------------------------------------
// Input channel (s_valid/s_ready/s_data): one transfer per tick or command.
// Result channel (m_valid/m_ready/m_data): exactly one result per input
// transfer, carrying the pin levels, step level, status and pulse count as
// they stand after that item.
// Latency: the result is valid the cycle after the input transfer.
// Throughput: one item per cycle unless stalled; the state update is one
// pass of counter and compare logic between state and result registers.
// s_ready is high whenever the result register is empty or being drained,
// so a new item enters in the same cycle a waiting result is taken.
// When the receiver stalls, the result holds and s_ready drops until the
// result is transferred.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index (0 half
// period, 1..4 dir/enable/reset/wake settle ticks); write only while idle.
// Reset (aresetn low, synchronous): phase idle, all pins and counters
// cleared, no result pending, registers back to 1, 1, 1, 1 and 2.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module stepper_step_dir_sequencer import ssd_pkg::*; #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  ssd_in_t    s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output ssd_out_t   m_data,
    input  logic       cfg_wr_en,
    input  logic [2:0] cfg_index,
    input  logic [9:0] cfg_wdata
);

    ssd_cfg_t cfg_reg, cfg_next;
    ssd_cmd_t cmd;
    ssd_out_t res;
    ssd_out_t m_data_reg;
    logic     m_valid_reg, m_valid_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_STEP_HALF:   cfg_next.step_half_period    = cfg_wdata[7:0];
                CFG_DIR_SETTLE:  cfg_next.dir_settle_ticks    = cfg_wdata;
                CFG_EN_SETTLE:   cfg_next.enable_settle_ticks = cfg_wdata;
                CFG_RST_SETTLE:  cfg_next.reset_settle_ticks  = cfg_wdata;
                CFG_WAKE_SETTLE: cfg_next.wake_settle_ticks   = cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.step_half_period    <= 8'd1;
            cfg_reg.dir_settle_ticks    <= 10'd1;
            cfg_reg.enable_settle_ticks <= 10'd1;
            cfg_reg.reset_settle_ticks  <= 10'd1;
            cfg_reg.wake_settle_ticks   <= 10'd2;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign s_ready    = !m_valid_reg || m_ready;
    assign cmd.accept = s_valid && s_ready;
    assign cmd.item   = s_data;

    ssd_core #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (cmd),
        .cfg    (cfg_reg),
        .res    (res)
    );

    // load on transfer, drop once taken
    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `ASSERT_NEXT(a_result_follows, aclk, aresetn, s_valid && s_ready, m_valid)
    `ASSERT_IMPLIES(a_stall_blocks, aclk, aresetn, m_valid && !m_ready, !s_ready)
    `ASSERT_IMPLIES(a_step_busy, aclk, aresetn, m_valid && m_data.step_out, m_data.busy_res)

endmodule
